/* sv/sac_pkg.sv */
// Package for the swept box collision block: contact normal codes.
// No dependencies.
package sac_pkg;
    localparam logic signed [15:0] NORM_ONE  = 16'sd16384;
    localparam logic signed [15:0] NORM_DIAG = 16'sd11585;
endpackage

/* sv/sac_div.sv */
// Pipelined saturating signed divider, one quotient bit per stage.
// Depends on nothing but its parameters.
module sac_div
#(
    parameter int NW = 34,
    parameter int DW = 33,
    parameter int CW = 32,
    parameter int FB = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic signed [NW-1:0] num,
    input  logic signed [DW-1:0] den,
    output logic signed [CW-1:0] quo
);
    // quotient bits computed: integer part limited to CW bits, plus FB fraction
    localparam int QB = CW + FB;
    localparam int RW = DW + 1;

    logic [NW-1:0]   un;
    logic [DW-1:0]   ud;
    logic            neg;
    assign un  = num[NW-1] ? NW'(-num) : NW'(num);
    assign ud  = den[DW-1] ? DW'(-den) : DW'(den);
    assign neg = num[NW-1] ^ den[DW-1];

    // wide dividend: magnitude with FB fraction zeros appended
    localparam int XW = NW + FB;
    logic [XW-1:0] dvd_reg [QB+1];
    logic [RW-1:0] rem_reg [QB+1];
    logic [QB-1:0] q_reg   [QB+1];
    logic [DW-1:0] d_reg   [QB+1];
    logic          n_reg   [QB+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dvd_reg[0] <= {un, {FB{1'b0}}};
            rem_reg[0] <= '0;
            q_reg[0]   <= '0;
            d_reg[0]   <= ud;
            n_reg[0]   <= neg;
        end
    end

    // stage 0 also tracks overflow if any quotient bit above QB would be set
    logic ovf_reg [QB+1];
    logic          ovf0;
    always_comb
    begin
        // quotient bits above QB are nonzero iff dividend high part >= divisor
        ovf0 = RW'(dvd_reg[0][XW-1:QB]) >= {1'b0, d_reg[0]};
    end
    always_ff @(posedge clk)
    begin
        if (en)
            ovf_reg[0] <= 1'b0;
    end

    for (genvar i = 0; i < QB; i++)
    begin : g_stage
        logic [RW-1:0] r_sh;
        logic          ge;
        logic          o;
        always_comb
        begin
            // stage 0 starts from the dividend bits down to the top bit of the quotient field
            if (i == 0)
                r_sh = RW'(dvd_reg[0][XW-1:QB-1]);
            else
                r_sh = {rem_reg[i][RW-2:0], dvd_reg[i][QB-1-i]};
            ge = r_sh >= {1'b0, d_reg[i]};
            o  = (i == 0) ? ovf0 : ovf_reg[i];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= ge ? RW'(r_sh - {1'b0, d_reg[i]}) : r_sh;
                q_reg[i+1]   <= {q_reg[i][QB-2:0], ge};
                dvd_reg[i+1] <= dvd_reg[i];
                d_reg[i+1]   <= d_reg[i];
                n_reg[i+1]   <= n_reg[i];
                ovf_reg[i+1] <= o;
            end
        end
    end

    // saturate magnitude to CW-bit signed range
    logic [QB:0]   lim;
    logic [QB:0]   mag;
    always_comb
    begin
        lim = {{(QB-CW+2){1'b0}}, {(CW-1){1'b1}}} + (QB+1)'(n_reg[QB]);
        mag = (ovf_reg[QB] || {1'b0, q_reg[QB]} > lim) ? lim : {1'b0, q_reg[QB]};
        quo = n_reg[QB] ? CW'(-mag) : CW'(mag);
    end

    logic unused;
    assign unused = rst_n;
endmodule

/* sv/swept_aabb_collision.sv */
// Swept 2D box collision: relative velocity, four saturating divisions,
// interval overlap and contact normal. Depends on sac_pkg and sac_div.
// Register order: stage 1, the bit-per-stage dividers, stage A, stage B.
// Throughput: one item per cycle; the whole pipe advances when the output is free.
// Reset clears all valid bits asynchronously; payload registers are not reset.
module swept_aabb_collision
    import sac_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // a_min_x, a_min_y, a_width, a_height, b_min_x, b_min_y, b_width, b_height,
    // a_vel_x, a_vel_y, b_vel_x, b_vel_y, zero pad
    input  logic [((12*COORD_WIDTH-4)+7)/8*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // hit, entry_time, normal_x, normal_y, zero pad
    output logic [((COORD_WIDTH+33)+7)/8*8-1:0] m_tdata
);
    localparam int CW = COORD_WIDTH;
    localparam int GW = CW + 2;
    localparam int VW = CW + 1;
    localparam int DL = CW + FRAC_BITS + 1;
    localparam int NST = DL + 3;
    localparam int OW = ((CW+33)+7)/8*8;

    // pipe advances unless the output holds an item nobody takes
    logic adv;
    assign adv = !m_tvalid || m_tready;
    assign s_tready = adv;

    logic signed [CW-1:0] ax, ay, bx, by, avx, avy, bvx, bvy;
    logic [CW-2:0] aw, ah, bw, bh;
    assign ax  = s_tdata[0*CW +: CW];
    assign ay  = s_tdata[1*CW +: CW];
    assign aw  = s_tdata[2*CW +: CW-1];
    assign ah  = s_tdata[3*CW-1 +: CW-1];
    assign bx  = s_tdata[4*CW-2 +: CW];
    assign by  = s_tdata[5*CW-2 +: CW];
    assign bw  = s_tdata[6*CW-2 +: CW-1];
    assign bh  = s_tdata[7*CW-3 +: CW-1];
    assign avx = s_tdata[8*CW-4 +: CW];
    assign avy = s_tdata[9*CW-4 +: CW];
    assign bvx = s_tdata[10*CW-4 +: CW];
    assign bvy = s_tdata[11*CW-4 +: CW];

    // stage 1: gaps and relative velocity
    logic signed [GW-1:0] ex_reg, lx_reg, ey_reg, ly_reg;
    logic signed [VW-1:0] vx_reg, vy_reg;
    logic [NST-1:0] vld_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ex_reg <= GW'(bx) - GW'(ax) - GW'({1'b0, aw});
            lx_reg <= GW'(bx) + GW'({1'b0, bw}) - GW'(ax);
            ey_reg <= GW'(by) - GW'(ay) - GW'({1'b0, ah});
            ly_reg <= GW'(by) + GW'({1'b0, bh}) - GW'(ay);
            vx_reg <= VW'(avx) - VW'(bvx);
            vy_reg <= VW'(avy) - VW'(bvy);
        end
    end

    // divisions; zero divisor replaced by one, result ignored
    logic signed [VW-1:0] dx, dy;
    assign dx = (vx_reg == '0) ? VW'(1) : vx_reg;
    assign dy = (vy_reg == '0) ? VW'(1) : vy_reg;
    logic signed [CW-1:0] t0x, t1x, t0y, t1y;
    sac_div #(.NW(GW), .DW(VW), .CW(CW), .FB(FRAC_BITS)) u_d0x
        (.clk, .rst_n, .en(adv), .num(ex_reg), .den(dx), .quo(t0x));
    sac_div #(.NW(GW), .DW(VW), .CW(CW), .FB(FRAC_BITS)) u_d1x
        (.clk, .rst_n, .en(adv), .num(lx_reg), .den(dx), .quo(t1x));
    sac_div #(.NW(GW), .DW(VW), .CW(CW), .FB(FRAC_BITS)) u_d0y
        (.clk, .rst_n, .en(adv), .num(ey_reg), .den(dy), .quo(t0y));
    sac_div #(.NW(GW), .DW(VW), .CW(CW), .FB(FRAC_BITS)) u_d1y
        (.clk, .rst_n, .en(adv), .num(ly_reg), .den(dy), .quo(t1y));

    // side info delayed alongside the dividers: zero flag, sign, static overlap
    typedef struct packed {
        logic zx, zy, nx, ny, okx, oky;
    } side_t;
    side_t side_reg [DL];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0].zx  <= vx_reg == '0;
            side_reg[0].zy  <= vy_reg == '0;
            side_reg[0].nx  <= vx_reg[VW-1];
            side_reg[0].ny  <= vy_reg[VW-1];
            side_reg[0].okx <= ex_reg < 0 && lx_reg > 0;
            side_reg[0].oky <= ey_reg < 0 && ly_reg > 0;
            for (int i = 1; i < DL; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // stage A: order intervals; infinities carried as out-of-range sentinel values (unbounded axis)
    localparam int TW = CW + 2;
    logic signed [TW-1:0] xlo_reg, xhi_reg, ylo_reg, yhi_reg;
    logic ok_reg, nxs_reg, nys_reg;
    side_t sd;
    assign sd = side_reg[DL-1];
    localparam logic signed [TW-1:0] NINF = {2'b11, {CW{1'b0}}};
    localparam logic signed [TW-1:0] PINF = {2'b01, {CW{1'b0}}};
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (sd.zx)
            begin
                xlo_reg <= NINF;
                xhi_reg <= PINF;
            end
            else
            begin
                xlo_reg <= (t0x > t1x) ? TW'(t1x) : TW'(t0x);
                xhi_reg <= (t0x > t1x) ? TW'(t0x) : TW'(t1x);
            end
            if (sd.zy)
            begin
                ylo_reg <= NINF;
                yhi_reg <= PINF;
            end
            else
            begin
                ylo_reg <= (t0y > t1y) ? TW'(t1y) : TW'(t0y);
                yhi_reg <= (t0y > t1y) ? TW'(t0y) : TW'(t1y);
            end
            ok_reg  <= (!sd.zx || sd.okx) && (!sd.zy || sd.oky);
            nxs_reg <= sd.nx;
            nys_reg <= sd.ny;
        end
    end

    // stage B: overlap, entry time and normal
    logic hit_reg;
    logic signed [CW-1:0] tin_reg;
    logic signed [15:0] nrx_reg, nry_reg;
    logic signed [TW-1:0] tin;
    logic h;
    always_comb
    begin
        h   = ok_reg && !(xhi_reg <= ylo_reg) && !(yhi_reg <= xlo_reg);
        tin = (xlo_reg > ylo_reg) ? xlo_reg : ylo_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg <= h;
            if (!h)
            begin
                tin_reg <= '0;
                nrx_reg <= '0;
                nry_reg <= '0;
            end
            else
            begin
                tin_reg <= (tin == NINF) ? {1'b1, {(CW-1){1'b0}}} : CW'(tin);
                if (ylo_reg < tin)
                begin
                    nrx_reg <= nxs_reg ? NORM_ONE : -NORM_ONE;
                    nry_reg <= '0;
                end
                else if (xlo_reg < tin)
                begin
                    nrx_reg <= '0;
                    nry_reg <= nys_reg ? NORM_ONE : -NORM_ONE;
                end
                else
                begin
                    nrx_reg <= nxs_reg ? NORM_DIAG : -NORM_DIAG;
                    nry_reg <= nys_reg ? NORM_DIAG : -NORM_DIAG;
                end
            end
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
    end

    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = OW'({nry_reg, nrx_reg, tin_reg, hit_reg});
endmodule

/* tb/tb_swept_aabb_collision.sv */
// Testbench for swept_aabb_collision: drives random and corner box pairs and
// checks every result against a built-in fixed-point predictor. Depends on sac_pkg and swept_aabb_collision.
module tb_swept_aabb_collision;
    import sac_pkg::*;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam int IN_W  = ((12*CW-4)+7)/8*8;
    localparam int OUT_W = ((CW+33)+7)/8*8;
    localparam int LATENCY = CW+FB+4;
    localparam longint T_MAX = 64'sd2147483647;
    localparam longint T_MIN = -64'sd2147483648;
    localparam longint T_NEG_INF = -(64'sd1 <<< 62);
    localparam longint T_POS_INF = (64'sd1 <<< 62);

    typedef struct packed {
        logic [15:0] ny;
        logic [15:0] nx;
        logic [31:0] entry_time;
        logic        hit;
    } contact_t;

    typedef struct {
        logic signed [31:0] ax, ay, bx, by, avx, avy, bvx, bvy;
        logic [30:0]        aw, ah, bw, bh;
    } pair_t;

    // Divide with truncation toward zero, FB fraction bits, signed 32-bit saturation.
    function automatic longint sat_quotient(longint num, longint den);
        logic neg;
        longint un, ud, lim, q, r, mag;
        neg = (num < 0) != (den < 0);
        un = num < 0 ? -num : num;
        ud = den < 0 ? -den : den;
        lim = neg ? T_MAX + 1 : T_MAX;
        q = un / ud;
        r = un % ud;
        if (q > (lim >>> FB)) mag = lim;
        else
        begin
            mag = q <<< FB;
            for (int i = FB-1; i >= 0; i--)
            begin
                r = r <<< 1;
                if (r >= ud)
                begin
                    r -= ud;
                    mag |= 64'sd1 <<< i;
                end
            end
            if (mag > lim) mag = lim;
        end
        return neg ? -mag : mag;
    endfunction

    // Time window on one axis; returns 0 when this axis excludes a hit.
    function automatic logic axis_window(longint amin, longint asz, longint bmin,
                                         longint bsz, longint v,
                                         output longint lo, output longint hi);
        longint gap_in, gap_out, t0, t1;
        gap_in = bmin - (amin + asz);
        gap_out = (bmin + bsz) - amin;
        lo = 0;
        hi = 0;
        if (v == 0)
        begin
            if (gap_in < 0 && gap_out > 0)
            begin
                lo = T_NEG_INF;
                hi = T_POS_INF;
                return 1'b1;
            end
            return 1'b0;
        end
        t0 = sat_quotient(gap_in, v);
        t1 = sat_quotient(gap_out, v);
        lo = t0 > t1 ? t1 : t0;
        hi = t0 > t1 ? t0 : t1;
        return 1'b1;
    endfunction

    function automatic contact_t predict_contact(pair_t p);
        contact_t c;
        longint vx, vy, xlo, xhi, ylo, yhi, tin;
        logic hx, hy, h;
        vx = longint'(p.avx) - longint'(p.bvx);
        vy = longint'(p.avy) - longint'(p.bvy);
        hx = axis_window(p.ax, longint'(p.aw), p.bx, longint'(p.bw), vx, xlo, xhi);
        hy = axis_window(p.ay, longint'(p.ah), p.by, longint'(p.bh), vy, ylo, yhi);
        h = hx && hy;
        if (h && (xhi <= ylo || yhi <= xlo)) h = 1'b0;
        c = '0;
        if (!h) return c;
        c.hit = 1'b1;
        tin = xlo > ylo ? xlo : ylo;
        if (ylo < tin)
            c.nx = vx >= 0 ? -NORM_ONE : NORM_ONE;
        else if (xlo < tin)
            c.ny = vy >= 0 ? -NORM_ONE : NORM_ONE;
        else
        begin
            c.nx = vx >= 0 ? -NORM_DIAG : NORM_DIAG;
            c.ny = vy >= 0 ? -NORM_DIAG : NORM_DIAG;
        end
        if (tin > T_MAX) tin = T_MAX;
        if (tin < T_MIN) tin = T_MIN;
        c.entry_time = tin[31:0];
        return c;
    endfunction

    class contact_scoreboard;
        contact_t expected_q[$];
        int errors = 0;
        int hits = 0;
        int checked = 0;

        function void note_pair(pair_t p);
            expected_q.push_back(predict_contact(p));
        endfunction

        function void check_contact(contact_t got);
            contact_t e;
            if (expected_q.size() == 0)
            begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (got.hit) hits++;
            if (got.hit !== e.hit)
            begin
                $display("%0t hit exp %b got %b", $time, e.hit, got.hit);
                errors++;
            end
            if (got.entry_time !== e.entry_time)
            begin
                $display("%0t entry_time exp %h got %h", $time, e.entry_time, got.entry_time);
                errors++;
            end
            if (got.nx !== e.nx)
            begin
                $display("%0t normal_x exp %h got %h", $time, e.nx, got.nx);
                errors++;
            end
            if (got.ny !== e.ny)
            begin
                $display("%0t normal_y exp %h got %h", $time, e.ny, got.ny);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    contact_scoreboard board = new();
    int sent = 0;

    swept_aabb_collision dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 clk = ~clk;

    // Fields packed from the lowest bit up, in port-comment order.
    function automatic logic [IN_W-1:0] pack_pair(pair_t p);
        logic [IN_W-1:0] d;
        d = '0;
        d[31:0]    = p.ax;
        d[63:32]   = p.ay;
        d[94:64]   = p.aw;
        d[125:95]  = p.ah;
        d[157:126] = p.bx;
        d[189:158] = p.by;
        d[220:190] = p.bw;
        d[251:221] = p.bh;
        d[283:252] = p.avx;
        d[315:284] = p.avy;
        d[347:316] = p.bvx;
        d[379:348] = p.bvy;
        return d;
    endfunction

    // Drop valid for a random gap, then hold the item until accepted.
    task automatic send_pair(pair_t p);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        if ($urandom_range(0, 1)) gap = 0;
        repeat (gap)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pack_pair(p);
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        board.note_pair(p);
        sent++;
    endtask

    function automatic logic signed [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(0, 40)) - 20 <<< 16;
            2: return $signed($urandom_range(0, 2000000)) - 1000000;
            default: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        endcase
    endfunction

    function automatic logic [30:0] rand_size(int mode);
        case (mode)
            0: return 31'($urandom());
            3: return $urandom_range(0, 1) ? 31'h7fffffff : 31'h0;
            default: return 31'(($urandom_range(0, 8) <<< 16)
                                | ($urandom_range(0, 1) ? $urandom_range(0, 65535) : 0));
        endcase
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        int m;
        m = $urandom_range(0, 9) < 7 ? 1 : $urandom_range(0, 3);
        p.ax = rand_coord(m); p.ay = rand_coord(m);
        p.bx = rand_coord(m); p.by = rand_coord(m);
        p.aw = rand_size(m); p.ah = rand_size(m);
        p.bw = rand_size(m); p.bh = rand_size(m);
        p.avx = rand_coord(m); p.avy = rand_coord(m);
        p.bvx = rand_coord(m); p.bvy = rand_coord(m);
        // zero relative velocity on one axis or on both
        case ($urandom_range(0, 5))
            0: p.bvx = p.avx;
            1: p.bvy = p.avy;
            2: begin p.bvx = p.avx; p.bvy = p.avy; end
            default: ;
        endcase
        return p;
    endfunction

    function automatic pair_t make_pair(int ax, int ay, int aw, int ah, int bx, int by,
                                        int bw, int bh, int vx, int vy);
        pair_t p;
        p.ax = ax <<< 16; p.ay = ay <<< 16;
        p.aw = 31'(aw <<< 16); p.ah = 31'(ah <<< 16);
        p.bx = bx <<< 16; p.by = by <<< 16;
        p.bw = 31'(bw <<< 16); p.bh = 31'(bh <<< 16);
        p.avx = vx <<< 16; p.avy = vy <<< 16; p.bvx = 0; p.bvy = 0;
        return p;
    endfunction

    // Drain side: stall at random, with long runs of always-ready.
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
            repeat (stall)
            begin
                m_tready <= 1'b0;
                @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            board.check_contact(m_tdata[CW+32:0]);
        end
    end

    initial
    begin
        pair_t p;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: plain hits from each side, corner, touching edges,
        // still axes overlapping and apart, both axes still, extremes.
        send_pair(make_pair(0, 0, 1, 1, 5, 0, 1, 1, 1, 0));
        send_pair(make_pair(5, 0, 1, 1, 0, 0, 1, 1, -1, 0));
        send_pair(make_pair(0, 0, 1, 1, 0, 5, 1, 1, 0, 1));
        send_pair(make_pair(0, 5, 1, 1, 0, 0, 1, 1, 0, -1));
        send_pair(make_pair(0, 0, 1, 1, 3, 3, 1, 1, 1, 1));
        send_pair(make_pair(3, 3, 1, 1, 0, 0, 1, 1, -1, -1));
        send_pair(make_pair(0, 0, 1, 1, 5, 1, 1, 1, 1, 0));
        send_pair(make_pair(0, 0, 1, 1, 5, 5, 1, 1, 0, 0));
        send_pair(make_pair(0, 0, 2, 2, 1, 1, 2, 2, 0, 0));
        send_pair(make_pair(0, 0, 1, 1, 2, 2, 1, 1, 1, 0));
        send_pair(make_pair(0, 0, 2, 2, 1, 1, 2, 2, 1, 1));
        send_pair(make_pair(0, 0, 1, 1, 0, 0, 0, 0, 1, 1));
        p = make_pair(0, 0, 1, 1, 100, 0, 1, 1, 0, 0);
        p.avx = 32'sh1; send_pair(p);
        p.avx = 32'sh80000000; p.bvx = 32'sh7fffffff; send_pair(p);
        p.avx = 32'sh7fffffff; p.bvx = 32'sh80000000; send_pair(p);
        p.ax = 32'sh80000000; p.ay = 32'sh7fffffff; p.aw = 31'h7fffffff;
        p.ah = 31'h7fffffff; p.bx = 32'sh7fffffff; p.by = 32'sh80000000;
        p.bw = 31'h7fffffff; p.bh = 31'h7fffffff; p.avy = 32'sh80000000;
        p.bvy = 32'sh7fffffff; send_pair(p);
        p = make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        p.avx = 32'sh80000000; p.bvy = 32'sh80000000; send_pair(p);

        // Hold off until the pipe is empty once.
        s_tvalid <= 1'b0;
        while (board.expected_q.size() != 0) @(posedge clk);

        for (int i = 0; i < 1500; i++)
        begin
            send_pair(random_pair());
            if (i == 750)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (board.expected_q.size() != 0) @(posedge clk);
            end
        end
        s_tvalid <= 1'b0;
        while (board.expected_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        $display("Sent %0d box pairs, checked %0d results, %0d hits.",
                 sent, board.checked, board.hits);
        if (board.errors == 0 && board.expected_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

/* swept_aabb_collision.f */
sv/sac_pkg.sv
sv/sac_div.sv
sv/swept_aabb_collision.sv
tb/tb_swept_aabb_collision.sv
